@@ src/nps_pkg.sv @@
`timescale 1ns / 1ps

package nps_pkg;

    localparam int COORD_W   = 24;
    localparam int SQ_W      = 48;
    localparam int DIST_W    = 50;
    localparam int IDX_OUT_W = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOADED = 1'd1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

@@ src/nps_cell.sv @@
`timescale 1ns / 1ps

// One table entry. Loaded from the write port, or from the next cell
// while the table rotates toward the head.
module nps_cell
    import nps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_wr_en,
    input  t_point i_wr_point,
    input  logic   i_shift,
    input  t_point i_next_point,
    output t_point o_point
);

    t_point r_point;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_point <= i_wr_point;
        end else if (i_shift) begin
            r_point <= i_next_point;
        end
    end

    assign o_point = r_point;

endmodule

@@ src/nps_dist.sv @@
`timescale 1ns / 1ps

// Squared distance pipeline: |diff| -> squares -> sum, one register each.
module nps_dist
    import nps_pkg::*;
#(
    parameter int IW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [IW-1:0]     i_index,
    input  t_point            i_point,
    input  t_point            i_query,
    output logic              o_valid,
    output logic [IW-1:0]     o_index,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_busy
);

    logic                      r_v1, r_v2, r_v3;
    logic [IW-1:0]             r_i1, r_i2, r_i3;
    logic [COORD_W-1:0]        r_ax, r_ay, r_az;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]         r_sum;
    logic signed [COORD_W:0]   dx, dy, dz;
    logic [COORD_W:0]          n_ax, n_ay, n_az;

    assign dx = {i_point.x[COORD_W-1], i_point.x} - {i_query.x[COORD_W-1], i_query.x};
    assign dy = {i_point.y[COORD_W-1], i_point.y} - {i_query.y[COORD_W-1], i_query.y};
    assign dz = {i_point.z[COORD_W-1], i_point.z} - {i_query.z[COORD_W-1], i_query.z};

    // magnitude fits in COORD_W bits: |diff| <= 2^24 - 1
    assign n_ax = dx[COORD_W] ? (~dx + 1'b1) : dx;
    assign n_ay = dy[COORD_W] ? (~dy + 1'b1) : dy;
    assign n_az = dz[COORD_W] ? (~dz + 1'b1) : dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= i_index;
        r_ax  <= n_ax[COORD_W-1:0];
        r_ay  <= n_ay[COORD_W-1:0];
        r_az  <= n_az[COORD_W-1:0];
        r_i2  <= r_i1;
        r_sx  <= r_ax * r_ax;
        r_sy  <= r_ay * r_ay;
        r_sz  <= r_az * r_az;
        r_i3  <= r_i2;
        r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    end

    assign o_valid = r_v3;
    assign o_index = r_i3;
    assign o_dist  = r_sum;
    assign o_busy  = r_v1 | r_v2 | r_v3;

endmodule

@@ src/nearest_point_search.sv @@
`timescale 1ns / 1ps

// Nearest point search over a rotating table of MAX_POINTS 3-D points.
// Write: no result. Query: the table rotates through all MAX_POINTS entries (one entry per
// cycle), the distance pipe then drains, and the result strobe is registered after that.
// Next item may start in the strobe cycle.
// Reset (synchronous, active low) clears control and config; table entries
// stay undefined until written. The receiver cannot stall a result.
module nearest_point_search
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_func,
    input  logic [3:0]                i_point_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output logic                      o_valid,
    output logic                      o_found,
    output logic [IDX_OUT_W-1:0]      o_nearest_index,
    output logic [DIST_W-1:0]         o_dist_sq
);

    // step counter sized to hold MAX_POINTS, though it stops at MAX_POINTS - 1; index carried through the pipe
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int BIDX_W = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;
    localparam int NW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_step;
    logic [CFG_W-1:0]    r_point_count;
    logic                r_table_loaded;
    t_point              r_query;

    logic                r_have;
    logic [BIDX_W-1:0]   r_best_idx;
    logic [DIST_W-1:0]   r_best_d;

    logic                r_valid;
    logic                r_found;
    logic [IDX_OUT_W-1:0] r_nearest_index;
    logic [DIST_W-1:0]   r_dist_sq;

    logic                accept;
    logic                wr_item;
    logic                shift;
    logic                last_step;
    logic                issue;
    logic [NW-1:0]       n_eff;
    t_point              in_point;
    t_point              cells [MAX_POINTS];

    logic                dist_valid;
    logic [BIDX_W-1:0]   dist_index;
    logic [DIST_W-1:0]   dist_val;
    logic                dist_busy;

    assign accept  = i_start && !o_busy;
    assign wr_item = accept && (i_func == FUNC_WRITE);
    assign o_busy  = (r_state != S_IDLE);

    assign in_point.x = i_coord_x;
    assign in_point.y = i_coord_y;
    assign in_point.z = i_coord_z;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= '0;
            r_table_loaded <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data;
                CFG_TABLE_LOADED: r_table_loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // searched entries: point_count capped at table depth
    assign n_eff = (NW'(r_point_count) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                          : NW'(r_point_count);

    // ---------------- cell chain ----------------
    // During a scan every cell takes its neighbor's point, so during step t
    // the head holds entry t. MAX_POINTS shifts bring the table back home.
    genvar k;
    generate
        for (k = 0; k < MAX_POINTS; k++) begin : g_cell
            localparam logic [31:0] KK = k;
            logic wr_en;
            assign wr_en = wr_item && ({28'd0, i_point_index} == KK);
            nps_cell u_cell (
                .i_clk        (i_clk),
                .i_wr_en      (wr_en),
                .i_wr_point   (in_point),
                .i_shift      (shift),
                .i_next_point (cells[(k + 1) % MAX_POINTS]),
                .o_point      (cells[k])
            );
        end
    endgenerate

    // ---------------- sequencer ----------------
    assign shift     = (r_state == S_SCAN);
    assign last_step = (r_step == CNT_W'(MAX_POINTS - 1));
    assign issue     = shift && r_table_loaded && (NW'(r_step) < n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_func == FUNC_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!dist_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == S_SCAN) begin
            r_step <= last_step ? '0 : r_step + 1'b1;
        end else begin
            r_step <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_func == FUNC_QUERY)) begin
            r_query <= in_point;
        end
    end

    // ---------------- distance unit ----------------
    nps_dist #(
        .IW (BIDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_index (BIDX_W'(r_step)),
        .i_point (cells[0]),
        .i_query (r_query),
        .o_valid (dist_valid),
        .o_index (dist_index),
        .o_dist  (dist_val),
        .o_busy  (dist_busy)
    );

    // ---------------- running minimum ----------------
    // strict less-than keeps the lower index on ties (entries arrive in order)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (accept && (i_func == FUNC_QUERY)) begin
            r_have <= 1'b0;
        end else if (dist_valid) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_valid && (!r_have || (dist_val < r_best_d))) begin
            r_best_d   <= dist_val;
            r_best_idx <= dist_index;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DRAIN) && !dist_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DRAIN) && !dist_busy) begin
            r_found         <= r_have;
            r_nearest_index <= r_have ? r_best_idx[IDX_OUT_W-1:0] : '0;
            r_dist_sq       <= r_have ? r_best_d : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_nearest_index = r_nearest_index;
    assign o_dist_sq       = r_dist_sq;

    // ---------------- checks ----------------
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_nearest_index == '0 && o_dist_sq == '0))
        else $error("not-found result carries nonzero payload");

    a_dist_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_valid |-> (r_state != S_IDLE))
        else $error("distance produced outside a query");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_QUERY)) |=> (o_busy && !o_valid))
        else $error("query transfer did not start a scan");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_WRITE)) |=> !o_busy)
        else $error("write item left the block busy");

endmodule

@@ tb/tb_nearest_point_search.sv @@
`timescale 1ns / 1ps

module tb_nearest_point_search;
    import nps_pkg::*;

    localparam int MAX_POINTS      = 16;
    // settling wait, longer than a query takes from the start transfer to the result strobe
    localparam int SETTLE_CYCLES   = MAX_POINTS + 8;
    // cycles with no start transfer and no result strobe before the run is declared hung
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 120;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
        logic [DIST_W-1:0]    dsq;
    } t_answer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic                      i_func;
    logic [3:0]                i_point_index;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic signed [COORD_W-1:0] i_coord_z;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      o_valid;
    logic                      o_found;
    logic [IDX_OUT_W-1:0]      o_nearest_index;
    logic [DIST_W-1:0]         o_dist_sq;

    // Shadow of the point table and config, plus the queue of answers still owed.
    class nearest_scoreboard;
        t_point      pts[MAX_POINTS];
        logic [CFG_W-1:0] point_count;
        logic        table_loaded;
        t_answer     pending_answers[$];
        int          errors;

        function new();
            point_count  = '0;
            table_loaded = 1'b0;
            errors       = 0;
            foreach (pts[i]) pts[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_POINT_COUNT) begin
                point_count = data;
            end else if (idx == CFG_TABLE_LOADED) begin
                table_loaded = data[0];
            end
        endfunction

        function longint sq_gap(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            return d * d;
        endfunction

        // exhaustive scan; strict less-than keeps the lower index on ties
        function t_answer find_nearest(t_point q);
            t_answer ans;
            int      n;
            longint  d;
            ans = '0;
            n   = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
            if (table_loaded) begin
                for (int i = 0; i < n; i++) begin
                    d = sq_gap(pts[i].x, q.x) + sq_gap(pts[i].y, q.y) + sq_gap(pts[i].z, q.z);
                    if (!ans.found || DIST_W'(d) < ans.dsq) begin
                        ans.found = 1'b1;
                        ans.index = IDX_OUT_W'(i);
                        ans.dsq   = DIST_W'(d);
                    end
                end
            end
            return ans;
        endfunction

        function void note_item(logic func, logic [3:0] idx, t_point p);
            if (func == FUNC_WRITE) begin
                if (int'(idx) < MAX_POINTS) pts[idx] = p;
            end else begin
                pending_answers.push_back(find_nearest(p));
            end
        endfunction

        function void check_answer(logic found, logic [IDX_OUT_W-1:0] idx,
                                   logic [DIST_W-1:0] dsq);
            t_answer exp_ans;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: found=%0b index=%0d dist_sq=%0d", found, idx, dsq);
                errors++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (found !== exp_ans.found) begin
                $error("found: expected %0b, got %0b", exp_ans.found, found);
                errors++;
            end
            if (idx !== exp_ans.index) begin
                $error("nearest_index: expected %0d, got %0d", exp_ans.index, idx);
                errors++;
            end
            if (dsq !== exp_ans.dsq) begin
                $error("dist_sq: expected %0d, got %0d", exp_ans.dsq, dsq);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    nearest_scoreboard sb = new();
    int                quiet_cycles;

    nearest_point_search #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_func         (i_func),
        .i_point_index  (i_point_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_nearest_index(o_nearest_index),
        .o_dist_sq      (o_dist_sq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor. Inputs change only by NBA at the edge, so everything read here
    // is the value that the block itself sampled at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy) begin
                sb.note_item(i_func, i_point_index, '{x: i_coord_x, y: i_coord_y, z: i_coord_z});
            end
            if (o_valid) sb.check_answer(o_found, o_nearest_index, o_dist_sq);
        end
    end

    // Watchdog: any start transfer or result strobe counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] jitter(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return COORD_W'(v);
    endfunction

    // extremes, a cluster near the origin, or anything
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return jitter(4096);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
        return p;
    endfunction

    // Leaves start high after the transfer so the next item can follow back to back.
    task automatic send_item(logic func, logic [3:0] idx, t_point p);
        i_func        <= func;
        i_point_index <= idx;
        i_coord_x     <= p.x;
        i_coord_y     <= p.y;
        i_coord_z     <= p.z;
        i_start       <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause_sender(int pct);
        while ($urandom_range(0, 99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold off until every query in flight has answered
    task automatic wait_all_answered();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Full quiesce: answers in, trailing writes retired, block idle.
    task automatic wait_idle();
        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // both registers back to back; write enable stays up across the pair
    task automatic reconfigure(logic [CFG_W-1:0] count_val, logic [CFG_W-1:0] loaded_val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POINT_COUNT;
        i_cfg_data  <= count_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_TABLE_LOADED;
        i_cfg_data  <= loaded_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        t_point           p;
        t_point           a;
        t_point           b;
        int               pct;
        logic [CFG_W-1:0] cnt;
        logic             ld;

        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_func        <= FUNC_WRITE;
        i_point_index <= '0;
        i_coord_x     <= '0;
        i_coord_y     <= '0;
        i_coord_z     <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_POINT_COUNT;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // Reset config: empty, unloaded table -> not found.
        send_item(FUNC_QUERY, 4'hF, '{x: '0, y: '0, z: '0});

        // Fill the whole table before any query can cover an entry.
        // Entries 3 and 5 are identical to force a distance tie.
        send_item(FUNC_WRITE, 4'd0, '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX});
        send_item(FUNC_WRITE, 4'd1, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
        send_item(FUNC_WRITE, 4'd2, '{x: '0, y: '0, z: '0});
        send_item(FUNC_WRITE, 4'd3, '{x: 24'sd16, y: -24'sd32, z: 24'sd48});
        send_item(FUNC_WRITE, 4'd4, '{x: COORD_MAX, y: COORD_MIN, z: '0});
        send_item(FUNC_WRITE, 4'd5, '{x: 24'sd16, y: -24'sd32, z: 24'sd48});
        for (int i = 6; i < MAX_POINTS; i++) send_item(FUNC_WRITE, 4'(i), rand_point());

        // One point: opposite corner gives the largest possible distance.
        reconfigure(5'd1, 5'd1);
        send_item(FUNC_QUERY, 4'd0, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
        send_item(FUNC_QUERY, 4'd9, '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX});

        // Full table: tie goes to the lower index, exact hit, mixed corner.
        reconfigure(5'd16, 5'd1);
        send_item(FUNC_QUERY, 4'd5, '{x: 24'sd16, y: -24'sd32, z: 24'sd48});
        send_item(FUNC_QUERY, 4'd0, '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN});
        send_item(FUNC_QUERY, 4'd7, '{x: COORD_MAX, y: COORD_MIN, z: 24'sd1});

        // Count beyond depth is capped.
        reconfigure(5'd31, 5'd1);
        send_item(FUNC_QUERY, 4'd3, rand_point());

        // Unloaded table, then loaded but empty: both not found.
        reconfigure(5'd17, 5'b11110);
        send_item(FUNC_QUERY, 4'd1, rand_point());
        reconfigure(5'd0, 5'd1);
        send_item(FUNC_QUERY, 4'd2, rand_point());

        // ---- random phases ----
        // Sender idles 35% for four phases, 69% for four, then not at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: cnt = 5'd16;
                1: cnt = 5'd1;
                2: cnt = 5'd31;
                3: cnt = 5'd17;
                4: cnt = 5'd0;
                5: cnt = 5'd16;
                default: cnt = CFG_W'($urandom_range(2, MAX_POINTS));
            endcase
            ld  = (phase % 6 != 5);
            pct = (phase < 4) ? 35 : (phase < 8) ? 69 : 0;
            reconfigure(cnt, {(CFG_W-1)'($urandom), ld});

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 49) == 0) wait_all_answered();
                pause_sender(pct);
                a = sb.pts[$urandom_range(0, MAX_POINTS - 1)];
                b = sb.pts[$urandom_range(0, MAX_POINTS - 1)];
                if ($urandom_range(0, 9) < 3) begin
                    // table write: spread, clustered, or a copy of another entry
                    case ($urandom_range(0, 9))
                        4, 5: p = '{x: jitter(4096), y: jitter(4096), z: jitter(4096)};
                        6, 7: p = b;
                        default: p = rand_point();
                    endcase
                    send_item(FUNC_WRITE, 4'($urandom), p);
                end else begin
                    // query mostly around stored points so the scan has competition
                    case ($urandom_range(0, 9))
                        0, 1: p = rand_point();
                        2, 3, 4: p = a;
                        5, 6, 7: begin
                            p.x = a.x + jitter(255);
                            p.y = a.y + jitter(255);
                            p.z = a.z + jitter(255);
                        end
                        8: begin
                            p.x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                            p.y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                            p.z = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                        end
                        default: begin
                            p.x = (a.x >>> 1) + (b.x >>> 1);
                            p.y = (a.y >>> 1) + (b.y >>> 1);
                            p.z = (a.z >>> 1) + (b.z >>> 1);
                        end
                    endcase
                    send_item(FUNC_QUERY, 4'($urandom), p);
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ nearest_point_search.f @@
src/nps_pkg.sv
src/nps_cell.sv
src/nps_dist.sv
src/nearest_point_search.sv
tb/tb_nearest_point_search.sv
